// ===== src/convex_hull_graham_scan_core_macros.svh =====
// Assertion macros shared by the hull core.
`ifndef CONVEX_HULL_GRAHAM_SCAN_CORE_MACROS_SVH
`define CONVEX_HULL_GRAHAM_SCAN_CORE_MACROS_SVH

// Check b in the cycle after a, outside reset.
`define CHGS_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

// Check b in the cycle after reset is seen.
`define CHGS_ASSERT_RESET(lbl, b, msg) \
  lbl: assert property (@(posedge clk) rst |=> (b)) else $error(msg);

`endif

// ===== src/chgs_pkg.sv =====
// Types and constants shared by the convex hull core.
package chgs_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAN_W   = DIFF_W;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Item passed from the front end to the hull engine.
  typedef struct packed {
    point_t pt;
    logic   last;
    logic   keep;
    logic   ovf;
  } load_entry_t;

  typedef struct packed {
    point_t pt;
    logic   last;
    logic   dropped;
  } result_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_PIV_RD,
    ST_PIV_CMP,
    ST_SWAP0,
    ST_SWAP1,
    ST_SORT_LD,
    ST_SORT_TMP,
    ST_SORT_RD,
    ST_SORT_MUL,
    ST_SORT_CMP,
    ST_SORT_PLACE,
    ST_SCAN_LD,
    ST_SCAN_P,
    ST_SCAN_MUL,
    ST_SCAN_CMP,
    ST_SCAN_POPRD,
    ST_SCAN_POPDT,
    ST_SCAN_PUSH
  } state_t;

endpackage

// ===== src/chgs_fifo.sv =====
// Small register queue used between the stages and on the result side.
module chgs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [CW-1:0] cnt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== src/chgs_front.sv =====
// Front end: accept points, mark those that fit in the store, track overflow.
module chgs_front #(
  parameter int MAX_POINTS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  chgs_pkg::coord_t      point_x,
  input  chgs_pkg::coord_t      point_y,
  input  logic                  last_point,
  input  logic                  push,
  output logic                  full,
  output logic                  q_push,
  output chgs_pkg::load_entry_t q_entry,
  input  logic                  q_full
);
  import chgs_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0] cnt;
  logic          ovf;
  logic          keep;

  assign full   = q_full;
  assign q_push = push && !q_full;
  assign keep   = (cnt < CW'(MAX_POINTS));

  always_comb begin
    q_entry.pt.x = point_x;
    q_entry.pt.y = point_y;
    q_entry.last = last_point;
    q_entry.keep = keep;
    q_entry.ovf  = ovf || !keep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (q_push) begin
      if (last_point) begin
        cnt <= '0;
        ovf <= 1'b0;
      end else begin
        if (keep) begin
          cnt <= cnt + 1'b1;
        end
        ovf <= ovf || !keep;
      end
    end
  end

endmodule

// ===== src/chgs_back.sv =====
// Hull engine: point store, pivot search, insertion sort, scan and readout.
module chgs_back #(
  parameter int MAX_POINTS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  chgs_pkg::load_entry_t q_entry,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output chgs_pkg::result_t     res
);
  import chgs_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  function automatic logic [MAN_W-1:0] absd(input logic signed [DIFF_W-1:0] d);
    return d[DIFF_W-1] ? MAN_W'(-d) : MAN_W'(d);
  endfunction

  state_t state;
  state_t state_next;

  point_t mem [MAX_POINTS];
  point_t rdata;
  logic          we;
  logic [AW-1:0] wa;
  point_t        wd;
  logic [AW-1:0] ra;

  logic [CW-1:0] n;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] sz;
  logic [CW-1:0] k;
  logic [CW-1:0] emit_cnt;
  logic          ovf;
  point_t        pivot, tmp, cand, p, t1, t2, best, e0;
  logic [AW-1:0] bidx;

  logic signed [PROD_W-1:0] p1, p2;
  logic [MAN_W-1:0]         man_u, man_v;

  point_t co, cu, cv;
  logic signed [DIFF_W-1:0] dux, duy, dvx, dvy;
  logic signed [CROSS_W-1:0] cr;
  logic before_hit;
  logic pop_hit;
  logic better;
  logic [CW-1:0] eff;
  logic [CW-1:0] jm1;
  logic [CW-1:0] szm2;

  assign eff  = n + CW'(q_entry.keep);
  assign jm1  = j - 1'b1;
  assign szm2 = sz - CW'(2);

  // Shared cross product: (u - o) x (v - o).
  always_comb begin
    if (state == ST_SORT_MUL) begin
      co = pivot;
      cu = tmp;
      cv = rdata;
    end else begin
      co = t2;
      cu = t1;
      cv = p;
    end
    dux = DIFF_W'(cu.x) - DIFF_W'(co.x);
    duy = DIFF_W'(cu.y) - DIFF_W'(co.y);
    dvx = DIFF_W'(cv.x) - DIFF_W'(co.x);
    dvy = DIFF_W'(cv.y) - DIFF_W'(co.y);
  end

  assign cr = CROSS_W'(p1) - CROSS_W'(p2);
  // Collinear points lie on one ray from the pivot: Manhattan length orders them.
  assign before_hit = (cr > 0) || ((cr == 0) && (man_u < man_v));
  assign pop_hit    = (cr <= 0);
  assign better     = (rdata.y < best.y) || ((rdata.y == best.y) && (rdata.x < best.x));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (!q_empty && q_entry.last) begin
          state_next = (eff <= CW'(2)) ? ST_EMIT_RD : ST_PIV_RD;
        end
      end
      ST_EMIT_RD: state_next = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (!res_full) begin
          state_next = (k + 1'b1 == emit_cnt) ? ST_LOAD : ST_EMIT_RD;
        end
      end
      ST_PIV_RD:  state_next = ST_PIV_CMP;
      ST_PIV_CMP: state_next = (k + 1'b1 == n) ? ST_SWAP0 : ST_PIV_RD;
      ST_SWAP0:   state_next = ST_SWAP1;
      ST_SWAP1:   state_next = ST_SORT_LD;
      ST_SORT_LD: state_next = ST_SORT_TMP;
      ST_SORT_TMP: state_next = ST_SORT_RD;
      ST_SORT_RD: state_next = ST_SORT_MUL;
      ST_SORT_MUL: state_next = ST_SORT_CMP;
      ST_SORT_CMP: begin
        state_next = (before_hit && (jm1 > CW'(1))) ? ST_SORT_RD : ST_SORT_PLACE;
      end
      ST_SORT_PLACE: state_next = (i + 1'b1 == n) ? ST_SCAN_LD : ST_SORT_LD;
      ST_SCAN_LD: state_next = ST_SCAN_P;
      ST_SCAN_P:  state_next = (sz >= CW'(2)) ? ST_SCAN_MUL : ST_SCAN_PUSH;
      ST_SCAN_MUL: state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        state_next = (pop_hit && (sz - 1'b1 >= CW'(2))) ? ST_SCAN_POPRD : ST_SCAN_PUSH;
      end
      ST_SCAN_POPRD: state_next = ST_SCAN_POPDT;
      ST_SCAN_POPDT: state_next = ST_SCAN_MUL;
      ST_SCAN_PUSH: state_next = (i + 1'b1 == n) ? ST_EMIT_RD : ST_SCAN_LD;
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    we       = 1'b0;
    wa       = '0;
    wd       = q_entry.pt;
    ra       = k[AW-1:0];
    q_pop    = 1'b0;
    res_push = 1'b0;
    res.pt      = rdata;
    res.last    = (k + 1'b1 == emit_cnt);
    res.dropped = ovf;
    case (state)
      ST_LOAD: begin
        q_pop = !q_empty;
        we    = !q_empty && q_entry.keep;
        wa    = n[AW-1:0];
      end
      ST_EMIT_WR: res_push = !res_full;
      ST_SWAP0: begin
        we = 1'b1;
        wd = best;
      end
      ST_SWAP1: begin
        we = 1'b1;
        wa = bidx;
        wd = e0;
      end
      ST_SORT_LD: ra = i[AW-1:0];
      ST_SORT_RD: ra = jm1[AW-1:0];
      ST_SORT_CMP: begin
        we = before_hit;
        wa = j[AW-1:0];
        wd = cand;
      end
      ST_SORT_PLACE: begin
        we = 1'b1;
        wa = j[AW-1:0];
        wd = tmp;
      end
      ST_SCAN_LD: ra = i[AW-1:0];
      ST_SCAN_POPRD: ra = szm2[AW-1:0];
      ST_SCAN_PUSH: begin
        we = 1'b1;
        wa = sz[AW-1:0];
        wd = p;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      n     <= '0;
      i     <= '0;
      j     <= '0;
      sz    <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD: begin
          if (!q_empty) begin
            if (q_entry.keep) begin
              n <= n + 1'b1;
            end
            if (q_entry.last) begin
              n        <= eff;
              k        <= '0;
              emit_cnt <= eff;
              ovf      <= q_entry.ovf;
            end
          end
        end
        ST_EMIT_WR: begin
          if (!res_full) begin
            k <= k + 1'b1;
            if (k + 1'b1 == emit_cnt) begin
              n <= '0;
            end
          end
        end
        ST_PIV_CMP: begin
          if (k == '0 || better) begin
            best <= rdata;
            bidx <= k[AW-1:0];
          end
          if (k == '0) begin
            e0 <= rdata;
          end
          k <= k + 1'b1;
        end
        ST_SWAP0: pivot <= best;
        ST_SWAP1: i <= CW'(2);
        ST_SORT_TMP: begin
          tmp <= rdata;
          j   <= i;
        end
        ST_SORT_MUL: begin
          cand  <= rdata;
          p1    <= PROD_W'(dux) * PROD_W'(dvy);
          p2    <= PROD_W'(duy) * PROD_W'(dvx);
          man_u <= absd(dux) + absd(duy);
          man_v <= absd(dvx) + absd(dvy);
        end
        ST_SORT_CMP: begin
          if (before_hit) begin
            j <= jm1;
          end
        end
        ST_SORT_PLACE: begin
          i <= i + 1'b1;
          if (i + 1'b1 == n) begin
            i  <= '0;
            sz <= '0;
          end
        end
        ST_SCAN_P: p <= rdata;
        ST_SCAN_MUL: begin
          p1 <= PROD_W'(dux) * PROD_W'(dvy);
          p2 <= PROD_W'(duy) * PROD_W'(dvx);
        end
        ST_SCAN_CMP: begin
          if (pop_hit) begin
            sz <= sz - 1'b1;
            t1 <= t2;
          end
        end
        ST_SCAN_POPDT: t2 <= rdata;
        ST_SCAN_PUSH: begin
          t2 <= t1;
          t1 <= p;
          sz <= sz + 1'b1;
          i  <= i + 1'b1;
          if (i + 1'b1 == n) begin
            k        <= '0;
            emit_cnt <= sz + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/convex_hull_graham_scan_core.sv =====
// Top level of the Graham scan convex hull core.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  points in | push / full        | point_x, point_y, last_point
//  hull out  | pop / empty        | vertex_x, vertex_y, last_vertex, dropped
//
// Points load at one per cycle while the engine is idle. The last_point
// transaction starts the hull: pivot search, pivot swap, insertion sort, scan,
// then readout of each vertex (a set of two points or fewer goes straight to
// readout); all of it is bound by the single store port and the one shared
// cross-product unit. Reset clears queues and control; a full result queue
// stalls readout.
`include "convex_hull_graham_scan_core_macros.svh"

module convex_hull_graham_scan_core #(
  parameter int MAX_POINTS   = 32,
  parameter int QUEUE_DEPTH  = 4,
  parameter int RESULT_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  chgs_pkg::coord_t point_x,
  input  chgs_pkg::coord_t point_y,
  input  logic             last_point,
  input  logic             push,
  output logic             full,
  output chgs_pkg::coord_t vertex_x,
  output chgs_pkg::coord_t vertex_y,
  output logic             last_vertex,
  output logic             dropped,
  output logic             empty,
  input  logic             pop
);
  import chgs_pkg::*;

  // Front end to engine queue.
  logic        q_push;
  logic        q_full;
  load_entry_t q_in;
  load_entry_t q_out;
  logic        q_empty;
  logic        q_pop;

  // Engine to result queue.
  logic    res_push;
  logic    res_full;
  result_t res_in;
  result_t res_out;

  chgs_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .point_x   (point_x),
    .point_y   (point_y),
    .last_point(last_point),
    .push      (push),
    .full      (full),
    .q_push    (q_push),
    .q_entry   (q_in),
    .q_full    (q_full)
  );

  chgs_fifo #(
    .W    ($bits(load_entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_load_q (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_in),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_out),
    .empty(q_empty)
  );

  chgs_back #(
    .MAX_POINTS(MAX_POINTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_entry (q_out),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .res_full(res_full),
    .res_push(res_push),
    .res     (res_in)
  );

  chgs_fifo #(
    .W    ($bits(result_t)),
    .DEPTH(RESULT_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_in),
    .full (res_full),
    .pop  (pop),
    .dout (res_out),
    .empty(empty)
  );

  // Present the oldest waiting vertex.
  assign vertex_x    = res_out.pt.x;
  assign vertex_y    = res_out.pt.y;
  assign last_vertex = res_out.last;
  assign dropped     = res_out.dropped;

  `CHGS_ASSERT_RESET(a_reset_idle, empty && !full, "queues not cleared by reset")
  `CHGS_ASSERT_NEXT(a_res_stable, !res_push && !(pop && !empty), $stable(empty), "result queue changed without a transaction")
  `CHGS_ASSERT_NEXT(a_q_stays_empty, q_empty && !q_push, q_empty, "engine queue filled without a push")

endmodule

// ===== tb/sv/tb_convex_hull_graham_scan_core.sv =====
// Testbench for the Graham scan convex hull core: directed and random point sets checked against a predictor.
`timescale 1ns / 100ps

module tb_convex_hull_graham_scan_core;
  import chgs_pkg::*;

  localparam int CAP        = 32;
  localparam int ITEM_GOAL  = 380;
  localparam int HOLD_CYC   = 3000;
  localparam int HOLD_AFTER = 40;

  typedef struct {
    coord_t x;
    coord_t y;
    bit     lv;
    bit     dr;
  } vertex_t;

  // Scoreboard: keeps its own copy of the point store and the expected vertices.
  class hull_scoreboard;
    coord_t  px[CAP];
    coord_t  py[CAP];
    int      n_pts;
    bit      ovf;
    vertex_t pending[$];
    int      errors;

    function new();
      n_pts  = 0;
      ovf    = 0;
      errors = 0;
    endfunction

    // Cross product of (b - a) and (c - a), exact.
    function longint cross3(int a, int b, int c);
      longint bx, by, cx, cy;
      bx = longint'(px[b]) - longint'(px[a]);
      by = longint'(py[b]) - longint'(py[a]);
      cx = longint'(px[c]) - longint'(px[a]);
      cy = longint'(py[c]) - longint'(py[a]);
      return bx * cy - by * cx;
    endfunction

    function longint dist2(int p, int a);
      longint dx, dy;
      dx = longint'(px[a]) - longint'(px[p]);
      dy = longint'(py[a]) - longint'(py[p]);
      return dx * dx + dy * dy;
    endfunction

    // True when a sorts strictly ahead of b by angle about pivot p.
    function bit ahead(int p, int a, int b);
      longint c;
      c = cross3(p, a, b);
      if (c != 0) return c > 0;
      return dist2(p, a) < dist2(p, b);
    endfunction

    function void add_vertex(int idx, bit lv);
      vertex_t v;
      v.x  = px[idx];
      v.y  = py[idx];
      v.lv = lv;
      v.dr = ovf;
      pending = {pending, v};
    endfunction

    function void build_hull();
      int ord[CAP];
      int stk[CAP];
      int top, piv, tmp, i, j;
      if (n_pts <= 2) begin
        for (i = 0; i < n_pts; i++) add_vertex(i, i + 1 == n_pts);
        return;
      end
      for (i = 0; i < n_pts; i++) ord[i] = i;
      piv = 0;
      for (i = 1; i < n_pts; i++)
        if (py[i] < py[piv] || (py[i] == py[piv] && px[i] < px[piv])) piv = i;
      ord[0]   = piv;
      ord[piv] = 0;
      // Insertion sort of everything behind the pivot.
      for (i = 2; i < n_pts; i++) begin
        tmp = ord[i];
        j   = i;
        while (j > 1 && ahead(piv, tmp, ord[j-1])) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = tmp;
      end
      // Scan: drop collinear and right turns.
      top = 0;
      for (i = 0; i < n_pts; i++) begin
        while (top >= 2 && cross3(stk[top-2], stk[top-1], ord[i]) <= 0) top--;
        stk[top] = ord[i];
        top++;
      end
      for (i = 0; i < top; i++) add_vertex(stk[i], i + 1 == top);
    endfunction

    // Note one accepted point transaction.
    function void note_point(coord_t x, coord_t y, bit last);
      if (n_pts < CAP) begin
        px[n_pts] = x;
        py[n_pts] = y;
        n_pts++;
      end else begin
        ovf = 1;
      end
      if (last) begin
        build_hull();
        n_pts = 0;
        ovf   = 0;
      end
    endfunction

    // Check one accepted vertex transaction against the oldest expectation.
    function void check_vertex(coord_t x, coord_t y, bit lv, bit dr);
      vertex_t v;
      if (pending.size() == 0) begin
        $error("vertex with nothing expected: x=%0d y=%0d", x, y);
        errors++;
        return;
      end
      v = pending.pop_front();
      if (x !== v.x) begin
        $error("vertex_x expected %0d got %0d", v.x, x);
        errors++;
      end
      if (y !== v.y) begin
        $error("vertex_y expected %0d got %0d", v.y, y);
        errors++;
      end
      if (lv !== v.lv) begin
        $error("last_vertex expected %0d got %0d", v.lv, lv);
        errors++;
      end
      if (dr !== v.dr) begin
        $error("dropped expected %0d got %0d", v.dr, dr);
        errors++;
      end
    endfunction
  endclass

  logic   clk;
  logic   rst;
  coord_t point_x;
  coord_t point_y;
  logic   last_point;
  logic   push;
  logic   full;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   last_vertex;
  logic   dropped;
  logic   empty;
  logic   pop;

  hull_scoreboard sb;
  int n_sent;
  int n_popped;

  convex_hull_graham_scan_core DUT (
    .clk(clk), .rst(rst),
    .point_x(point_x), .point_y(point_y), .last_point(last_point),
    .push(push), .full(full),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .last_vertex(last_vertex),
    .dropped(dropped), .empty(empty), .pop(pop)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Draw an idle gap: often zero so back-to-back stretches occur.
  function automatic int draw_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Offer one point and hold it until the core takes the transaction.
  task automatic send_point(coord_t x, coord_t y, bit last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    point_x    <= x;
    point_y    <= y;
    last_point <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_point(x, y, last);
    n_sent++;
  endtask

  // Pick a coordinate: full range, a tight grid for collinear and duplicate hits, or an extreme.
  function automatic coord_t pick_coord(int mode);
    int k;
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'(($urandom_range(0, 6) - 3) * 16);
      default: begin
        k = $urandom_range(0, 2);
        if (k == 0) return coord_t'(-32768);
        if (k == 1) return coord_t'(32767);
        return coord_t'(0);
      end
    endcase
  endfunction

  // Sender: directed sets, then random sets.
  initial begin
    int sz, mode, i;
    sb         = new();
    n_sent     = 0;
    rst        = 1'b1;
    push       = 1'b0;
    point_x    = '0;
    point_y    = '0;
    last_point = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single point, echoed back.
    send_point(16'sd32767, -16'sd32768, 1);
    // Two points, echoed in order.
    send_point(-16'sd32768, -16'sd32768, 0);
    send_point(16'sd32767, 16'sd32767, 1);
    // Extreme square with an interior point.
    send_point(16'sd32767, 16'sd32767, 0);
    send_point(-16'sd32768, 16'sd32767, 0);
    send_point(16'sd0, 16'sd0, 0);
    send_point(16'sd32767, -16'sd32768, 0);
    send_point(-16'sd32768, -16'sd32768, 1);
    // Duplicate pivot, collinear edges and a tie on the pivot row.
    send_point(16'sd0, 16'sd0, 0);
    send_point(16'sd0, 16'sd0, 0);
    send_point(16'sd32, 16'sd0, 0);
    send_point(16'sd16, 16'sd0, 0);
    send_point(16'sd16, 16'sd16, 0);
    send_point(16'sd0, 16'sd32, 0);
    send_point(16'sd0, 16'sd16, 1);
    // Triangle, clockwise input.
    send_point(16'sd5, 16'sd100, 0);
    send_point(16'sd200, -16'sd3, 0);
    send_point(-16'sd7, -16'sd3, 1);

    // Random sets; the first one overflows the store.
    sz = 34;
    while (n_sent < ITEM_GOAL) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 5) ? 0 : (mode < 9) ? 1 : 2;
      for (i = 0; i < sz; i++)
        send_point(pick_coord(mode), pick_coord(mode), i == sz - 1);
      case ($urandom_range(0, 19))
        0:       sz = $urandom_range(33, 38);
        1, 2:    sz = $urandom_range(1, 2);
        default: sz = $urandom_range(3, 12);
      endcase
    end
    push <= 1'b0;

    // Drain: every vertex must come back, then let the core settle.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_convex_hull_graham_scan_core: done, clean");
    end else begin
      $display("tb_convex_hull_graham_scan_core: done, errors");
    end
    $finish;
  end

  // Receiver: random pop gaps, plus one long hold-off so the core backs up to its input.
  initial begin
    int gap;
    n_popped = 0;
    pop      = 1'b0;
    @(negedge rst);
    forever begin
      if (n_popped == HOLD_AFTER) begin
        pop <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        n_popped++;
      end
      gap = draw_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      sb.check_vertex(vertex_x, vertex_y, last_vertex, dropped);
      n_popped++;
    end
  end

  // Hard stop in case the core hangs.
  initial begin
    #4000000;
    $display("tb_convex_hull_graham_scan_core: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/chgs_pkg.sv
src/chgs_fifo.sv
src/chgs_front.sv
src/chgs_back.sv
src/convex_hull_graham_scan_core.sv
tb/sv/tb_convex_hull_graham_scan_core.sv
